// ===== rtl/mslvs_pkg.sv =====
// package for the minimal standard lcg vector source
// holds generator constants, field widths, command and register codes
// no dependencies
`default_nettype none

package mslvs_pkg;

	localparam int unsigned SEED_W  = 31;
	localparam int unsigned DIMS_W  = 7;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned PATH_W  = 16;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned PROD_W  = 2 * SEED_W;
	localparam int unsigned EXP_W   = PATH_W + DIMS_W;
	localparam int unsigned IN_W    = 16;
	localparam int unsigned OUT_W   = 40;
	localparam int unsigned CFG_W   = SEED_W;
	localparam int unsigned CIDX_W  = 1;

	localparam int unsigned MAX_DIMENSIONS_DEF = 64;

	localparam logic [SEED_W-1:0] LCG_MULT = 31'd16807;
	localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7fff_ffff;

	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SKIP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

	localparam logic [CIDX_W-1:0] REG_INIT_SEED  = 1'b0;
	localparam logic [CIDX_W-1:0] REG_DIMENSIONS = 1'b1;

	// mersenne fold of a product of two values below the modulus
	function automatic logic [SEED_W-1:0] mod_reduce(input logic [PROD_W-1:0] p);
		logic [SEED_W:0] s1;
		logic [SEED_W:0] s2;
		logic [SEED_W:0] r;
		s1 = {1'b0, p[SEED_W-1:0]} + {1'b0, p[PROD_W-1:SEED_W]};
		s2 = {1'b0, s1[SEED_W-1:0]} + {{SEED_W{1'b0}}, s1[SEED_W]};
		r  = (s2 >= {1'b0, LCG_MOD}) ? (s2 - {1'b0, LCG_MOD}) : s2;
		return r[SEED_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/minimal_standard_lcg_vector_source_core.sv =====
// top level of the minimal standard lcg vector source
// one shared 31x31 modular multiplier under a small sequencer
// depends on mslvs_pkg
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tuser: command, tdata: path_count
// m_       out  m_tvalid/m_tready  tdata: variate, position; tlast: last
// cfg_     in   cfg_wen            cfg_index, cfg_data
//
// draw: after the accept in idle, each variate takes a multiply state, then a fold state
// skip: accept, then the length multiply and exponent load states, then per exponent bit a check,
//   a seed multiply and fold if the bit is set, a square and fold, and one final check; exponent up to 22 bits
// reset command: reloads the seed without leaving idle; s_tready is high only while the sequencer is idle
// a full output register stalls the fold step until m_tready
// arst_n clears the seed and both registers to one
`default_nettype none

module minimal_standard_lcg_vector_source_core #(
	parameter int unsigned MAX_DIMENSIONS = mslvs_pkg::MAX_DIMENSIONS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [mslvs_pkg::IN_W-1:0]       s_tdata,  // [15:0] path_count
	input  wire  [mslvs_pkg::CMD_W-1:0]      s_tuser,  // [1:0] command
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [mslvs_pkg::OUT_W-1:0]      m_tdata,  // [30:0] variate, [36:31] position
	output logic                             m_tlast,
	input  wire                              cfg_wen,
	input  wire  [mslvs_pkg::CIDX_W-1:0]     cfg_index,
	input  wire  [mslvs_pkg::CFG_W-1:0]      cfg_data
);

	localparam int unsigned SW = mslvs_pkg::SEED_W;
	localparam int unsigned DW = mslvs_pkg::DIMS_W;
	localparam int unsigned PW = mslvs_pkg::POS_W;
	localparam int unsigned EW = mslvs_pkg::EXP_W;
	localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIMENSIONS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DRAW_MUL,
		S_DRAW_RED,
		S_SKIP_LEN,
		S_SKIP_EXP,
		S_SKIP_CHK,
		S_SEED_MUL,
		S_SEED_RED,
		S_SQ_MUL,
		S_SQ_RED
	} state_t;

	state_t                      state_q;
	logic [SW-1:0]               seed_q;
	logic [SW-1:0]               init_seed_q;
	logic [DW-1:0]               dims_q;
	logic [mslvs_pkg::PATH_W-1:0] paths_q;
	logic [SW-1:0]               base_q;
	logic [EW-1:0]               exp_q;
	logic [PW-1:0]               pos_q;
	logic [mslvs_pkg::PROD_W-1:0] prod_q;
	logic                        out_valid_q;
	logic [SW-1:0]               out_variate_q;
	logic [PW-1:0]               out_pos_q;
	logic                        out_last_q;

	logic [SW-1:0] op_a;
	logic [SW-1:0] op_b;
	logic [SW-1:0] red;
	logic [DW-1:0] dims_eff;
	logic [SW-1:0] load_val;
	logic          out_free;
	logic          out_load;
	logic          pos_last;

	assign dims_eff = (dims_q > DIM_MAX) ? DIM_MAX : dims_q;
	assign red      = mslvs_pkg::mod_reduce(prod_q);
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == S_DRAW_RED) && out_free;
	assign pos_last = (({1'b0, pos_q} + DW'(1)) == dims_eff);
	assign load_val = (init_seed_q == mslvs_pkg::LCG_MOD || init_seed_q == '0)
		? SW'(1) : init_seed_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(mslvs_pkg::OUT_W - SW - PW){1'b0}}, out_pos_q, out_variate_q};
	assign m_tlast  = out_last_q;

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			S_DRAW_MUL, S_DRAW_RED: begin
				op_a = seed_q;
				op_b = mslvs_pkg::LCG_MULT;
			end
			S_SKIP_LEN: begin
				op_a = SW'(paths_q);
				op_b = SW'(dims_eff);
			end
			S_SEED_MUL: begin
				op_a = seed_q;
				op_b = base_q;
			end
			S_SQ_MUL: begin
				op_a = base_q;
				op_b = base_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mslvs_pkg::PROD_W'(op_a) * mslvs_pkg::PROD_W'(op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_q      <= SW'(1);
			init_seed_q <= SW'(1);
			dims_q      <= DW'(1);
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					mslvs_pkg::REG_INIT_SEED:  init_seed_q <= cfg_data;
					mslvs_pkg::REG_DIMENSIONS: dims_q <= cfg_data[DW-1:0];
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						paths_q <= s_tdata[mslvs_pkg::PATH_W-1:0];
						pos_q   <= '0;
						priority case (s_tuser)
							mslvs_pkg::CMD_DRAW: begin
								if (dims_eff != '0) begin
									state_q <= S_DRAW_MUL;
								end
							end
							mslvs_pkg::CMD_SKIP: begin
								state_q <= S_SKIP_LEN;
							end
							mslvs_pkg::CMD_RESET: begin
								seed_q <= load_val;
							end
							default: begin
							end
						endcase
					end
				end
				S_DRAW_MUL: begin
					state_q <= S_DRAW_RED;
				end
				S_DRAW_RED: begin
					if (out_free) begin
						seed_q        <= red;
						out_variate_q <= red;
						out_pos_q     <= pos_q;
						out_last_q    <= pos_last;
						pos_q         <= pos_q + PW'(1);
						state_q       <= pos_last ? S_IDLE : S_DRAW_MUL;
					end
				end
				S_SKIP_LEN: begin
					state_q <= S_SKIP_EXP;
				end
				S_SKIP_EXP: begin
					exp_q   <= prod_q[EW-1:0];
					base_q  <= mslvs_pkg::LCG_MULT;
					state_q <= S_SKIP_CHK;
				end
				S_SKIP_CHK: begin
					priority if (exp_q == '0) begin
						state_q <= S_IDLE;
					end else if (exp_q[0]) begin
						state_q <= S_SEED_MUL;
					end else begin
						state_q <= S_SQ_MUL;
					end
				end
				S_SEED_MUL: begin
					state_q <= S_SEED_RED;
				end
				S_SEED_RED: begin
					seed_q  <= red;
					state_q <= S_SQ_MUL;
				end
				S_SQ_MUL: begin
					state_q <= S_SQ_RED;
				end
				S_SQ_RED: begin
					base_q  <= red;
					exp_q   <= exp_q >> 1;
					state_q <= S_SKIP_CHK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for minimal_standard_lcg_vector_source_core
// predicts every variate of draw, skip and reload requests and checks the output stream
// depends on mslvs_pkg and the core rtl
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mslvs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	localparam longint unsigned  MODULUS = 64'd2147483647;
	localparam int TB_MAX_DIMS    = MAX_DIMENSIONS_DEF;
	localparam int SETTLE_CYCLES  = 200;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [PATH_W-1:0] paths;
	} request_t;

	typedef struct packed {
		logic [SEED_W-1:0] variate;
		logic [POS_W-1:0]  position;
		logic              last;
	} variate_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata   = '0;
	logic [CMD_W-1:0]    s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tlast;
	logic                cfg_wen   = 1'b0;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data  = '0;

	request_t pending_q[$];
	variate_t variate_q[$];

	logic [SEED_W-1:0] lcg_seed  = 31'd1;
	logic [SEED_W-1:0] cfg_seed  = 31'd1;
	logic [DIMS_W-1:0] cfg_dims  = 7'd1;

	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int tx_gap = 0;
	int rx_stall = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int quiet_cycles = 0;
	int n_draw = 0, n_skip = 0, n_reload = 0, n_ignored = 0;
	int n_settings = 0, n_results = 0, n_errors = 0;

	minimal_standard_lcg_vector_source_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),  // [15:0] path_count
		.s_tuser   (s_tuser),  // [1:0] command
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),  // [30:0] variate, [36:31] position
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [SEED_W-1:0] mul_mod(input logic [SEED_W-1:0] a,
			input logic [SEED_W-1:0] b);
		logic [63:0] prod;
		prod = 64'(a) * 64'(b);
		return SEED_W'(prod % MODULUS);
	endfunction

	function automatic logic [SEED_W-1:0] multiplier_power(input logic [EXP_W-1:0] n);
		logic [SEED_W-1:0] acc;
		logic [SEED_W-1:0] base;
		logic [EXP_W-1:0]  e;
		acc = 31'd1;
		base = LCG_MULT;
		e = n;
		while (e != 0) begin
			if (e[0])
				acc = mul_mod(acc, base);
			base = mul_mod(base, base);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic int active_dims();
		return (int'(cfg_dims) > TB_MAX_DIMS) ? TB_MAX_DIMS : int'(cfg_dims);
	endfunction

	task automatic predict_request(input logic [CMD_W-1:0] cmd, input logic [PATH_W-1:0] paths);
		variate_t v;
		int dims;
		int j;
		dims = active_dims();
		case (cmd)
			CMD_DRAW: begin
				n_draw++;
				for (j = 0; j < dims; j++) begin
					lcg_seed = mul_mod(lcg_seed, LCG_MULT);
					v.variate = lcg_seed;
					v.position = POS_W'(j);
					v.last = (j == dims - 1);
					variate_q.push_back(v);
				end
			end
			CMD_SKIP: begin
				n_skip++;
				lcg_seed = mul_mod(lcg_seed, multiplier_power(EXP_W'(paths) * EXP_W'(dims)));
			end
			CMD_RESET: begin
				n_reload++;
				if (cfg_seed == LCG_MOD || cfg_seed == 31'd0)
					lcg_seed = 31'd1;
				else
					lcg_seed = cfg_seed;
			end
			default: n_ignored++;
		endcase
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_request(s_tuser, s_tdata[PATH_W-1:0]);
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					request_t req;
					req = pending_q.pop_front();
					s_tuser <= req.cmd;
					s_tdata <= IN_W'(req.paths);
					s_tvalid <= 1'b1;
					tx_gap = tx_idle ? $urandom_range(0, 17) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(input string field, input longint want, input longint got);
		n_errors++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// variate monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				variate_t got;
				variate_t want;
				got.variate = m_tdata[SEED_W-1:0];
				got.position = m_tdata[SEED_W+POS_W-1:SEED_W];
				got.last = m_tlast;
				n_results++;
				if (variate_q.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected variate, expected none, got %0d at position %0d",
						$time, got.variate, got.position);
				end else begin
					want = variate_q.pop_front();
					if (got.variate !== want.variate)
						report_mismatch("variate", want.variate, got.variate);
					if (got.position !== want.position)
						report_mismatch("position", want.position, got.position);
					if (got.last !== want.last)
						report_mismatch("last", want.last, got.last);
				end
				rx_stall = rx_idle ? $urandom_range(0, 17) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d variates still awaited",
				$time, quiet_cycles, variate_q.size());
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [PATH_W-1:0] paths);
		request_t req;
		req.cmd = cmd;
		req.paths = paths;
		pending_q.push_back(req);
	endtask

	// waits for the last variate, then lets a skip finish before touching registers
	task automatic drain_and_settle();
		while (pending_q.size() != 0 || s_tvalid || variate_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_regs(input logic [SEED_W-1:0] seed, input logic [DIMS_W-1:0] dims);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= REG_INIT_SEED;
		cfg_data <= seed;
		cfg_seed = seed;
		@(posedge clk);
		cfg_index <= REG_DIMENSIONS;
		cfg_data <= CFG_W'(dims);
		cfg_dims = dims;
		@(posedge clk);
		cfg_wen <= 1'b0;
		n_settings++;
		@(negedge clk);
	endtask

	function automatic logic [SEED_W-1:0] pick_seed();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return LCG_MOD;
			2: return 31'd2147483646;
			3: return 31'd1;
			default: return SEED_W'($urandom);
		endcase
	endfunction

	function automatic logic [DIMS_W-1:0] pick_dims();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd64;
			2: return DIMS_W'($urandom_range(65, 127));
			3: return DIMS_W'($urandom_range(9, 63));
			default: return DIMS_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [PATH_W-1:0] pick_paths();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hffff;
			2: return PATH_W'($urandom_range(1, 4));
			default: return PATH_W'($urandom);
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return CMD_DRAW;
		else if (r < 82)
			return CMD_SKIP;
		else if (r < 94)
			return CMD_RESET;
		return CMD_NOP;
	endfunction

	initial begin
		int ph;
		int k;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: seed one, one variate per vector
		queue_request(CMD_DRAW, 16'h0000);
		queue_request(CMD_DRAW, 16'hffff);
		queue_request(CMD_SKIP, 16'h0000);
		queue_request(CMD_DRAW, 16'h0000);
		queue_request(CMD_SKIP, 16'h0001);
		queue_request(CMD_DRAW, 16'h0000);
		queue_request(CMD_NOP, 16'hffff);
		queue_request(CMD_DRAW, 16'h0000);
		queue_request(CMD_RESET, 16'h0000);
		queue_request(CMD_DRAW, 16'h0000);
		drain_and_settle();

		// zero seed, full vectors, receiver held off so the core backs up
		write_regs(31'd0, 7'd64);
		hold_req++;
		queue_request(CMD_RESET, 16'h0000);
		queue_request(CMD_DRAW, 16'h0000);
		queue_request(CMD_SKIP, 16'hffff);
		queue_request(CMD_DRAW, 16'h5555);
		queue_request(CMD_DRAW, 16'haaaa);
		drain_and_settle();

		// seed equal to the modulus, empty vectors
		write_regs(LCG_MOD, 7'd0);
		queue_request(CMD_RESET, 16'h0000);
		queue_request(CMD_DRAW, 16'h0000);
		queue_request(CMD_SKIP, 16'h1234);
		queue_request(CMD_NOP, 16'h0000);
		drain_and_settle();

		// dimension count above the maximum saturates
		write_regs(31'd2147483646, 7'd127);
		queue_request(CMD_RESET, 16'h0000);
		queue_request(CMD_DRAW, 16'h0000);
		queue_request(CMD_SKIP, 16'hffff);
		queue_request(CMD_DRAW, 16'h0000);
		drain_and_settle();

		for (ph = 0; ph < 10; ph++) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			write_regs(pick_seed(), pick_dims());
			queue_request(CMD_RESET, PATH_W'($urandom));
			for (k = 0; k < 48; k++)
				queue_request(pick_command(), pick_paths());
			drain_and_settle();
		end

		$display("covered %0d draws, %0d skips, %0d reloads and %0d ignored requests over %0d settings",
			n_draw, n_skip, n_reload, n_ignored, n_settings);
		$display("%0d variates compared, %0d mismatches", n_results, n_errors);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
